FILE: hdl/mpf_pkg.sv
// mpf_pkg: shared types and constants for the mouse packet framer FIFO.
// No dependencies; imported by mouse_packet_framer_fifo and mpf_checker.
package mpf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PacketW = 3 * ByteW;

  localparam logic [ByteW-1:0] SYNC_BIT = 8'h08;
  localparam logic [ByteW-1:0] YOVF_BIT = 8'h80;
  localparam logic [ByteW-1:0] XOVF_BIT = 8'h40;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [PacketW-1:0] packet_word;
    logic               empty_res;
  } out_t;

endpackage

FILE: hdl/mpf_ram.sv
// mpf_ram: generic simple dual-port RAM, one write port, one registered read port.
// No package dependencies.
module mpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mouse_packet_framer_fifo.sv
// mouse_packet_framer_fifo: frames PS/2 mouse bytes into packets and queues them.
// Depends on mpf_pkg and mpf_ram.
//
//  channel   ports                      transfer when
//  -------   -------------------------  -------------------------------
//  command   start_i, busy_o, item_i    start_i high and busy_o low
//  result    done_o, res_o              done_o high (one cycle, no stall)
//
// One item is taken every cycle; busy_o stays low.
// A read request returns its result in the cycle after it is taken, through the
// registered read port of the packet RAM. Mouse bytes produce no result.
// Reset clears the framer phase, pointers and fill count; the packet RAM is
// not cleared, since only written entries are ever read.
// The result receiver cannot stall: each result is shown for exactly one cycle.
module mouse_packet_framer_fifo
  import mpf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  item_i,
  output logic done_o,
  output out_t res_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  // framer state
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] second_q, second_d;

  // FIFO bookkeeping
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // result stage
  logic done_q, done_d;
  logic empty_q, empty_d;

  logic               accept;
  logic               push;
  logic               pop;
  logic [PacketW-1:0] rd_data;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    push     = 1'b0;
    pop      = 1'b0;
    done_d   = 1'b0;
    empty_d  = empty_q;

    if (accept && item_i.kind == KIND_BYTE) begin
      unique case (phase_q)
        PH_SECOND: begin
          second_d = item_i.rx_byte;
          phase_d  = PH_THIRD;
        end
        PH_THIRD: begin
          // overflow packets dropped, full FIFO drops silently
          push    = ((first_q & (YOVF_BIT | XOVF_BIT)) == '0) && (count_q != CntFull);
          phase_d = PH_FIRST;
        end
        default: begin
          // waiting for a first byte; also covers the unused phase code
          phase_d = PH_FIRST;
          if ((item_i.rx_byte & SYNC_BIT) != '0) begin
            first_d = item_i.rx_byte;
            phase_d = PH_SECOND;
          end
        end
      endcase
    end

    if (accept && item_i.kind == KIND_READ) begin
      done_d  = 1'b1;
      empty_d = (count_q == '0);
      pop     = (count_q != '0);
    end
  end

  // pointers wrap at FIFO_DEPTH, which need not be a power of two
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      first_q  <= '0;
      second_q <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      done_q   <= done_d;
      empty_q  <= empty_d;
    end
  end

  mpf_ram #(
    .WIDTH(PacketW),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(wr_ptr_q),
    .wdata_i({first_q, second_q, item_i.rx_byte}),
    .re_i   (pop),
    .raddr_i(rd_ptr_q),
    .rdata_o(rd_data)
  );

  // empty read returns a zero word
  assign done_o            = done_q;
  assign res_o.packet_word = empty_q ? '0 : rd_data;
  assign res_o.empty_res   = empty_q;

endmodule

FILE: hdl/mpf_checker.sv
// mpf_checker: port-level assertions for mouse_packet_framer_fifo, plus its bind.
// Depends on mpf_pkg.
module mpf_checker
  import mpf_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input in_t  item_i,
  input logic done_o,
  input out_t res_o
);

  // a read request yields a result in the next cycle
  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.kind == KIND_READ) |=> done_o)
    else $error("read request without result");

  // a mouse byte never yields a result
  a_byte_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.kind == KIND_BYTE) |=> !done_o)
    else $error("result after mouse byte");

  // every result traces back to a read request
  a_result_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && item_i.kind == KIND_READ))
    else $error("result without read request");

  // empty results carry a zero word
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.empty_res) |-> (res_o.packet_word == '0))
    else $error("empty result with nonzero word");

endmodule

bind mouse_packet_framer_fifo mpf_checker u_mpf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .item_i (item_i),
  .done_o (done_o),
  .res_o  (res_o)
);
